// ===== hw/rtl/morse_text_encoder_assert.svh =====
// ----------------------------------------------------------------------------
// morse_text_encoder assertion macros
// Concurrent assertion wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef MORSE_TEXT_ENCODER_ASSERT_SVH
`define MORSE_TEXT_ENCODER_ASSERT_SVH

`ifndef SYNTH
`define MTE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("morse_text_encoder assertion failed");
`else
`define MTE_ASSERT(lbl, prop)
`endif

`ifndef SYNTH
`define MTE_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("morse_text_encoder assertion failed");
`else
`define MTE_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== hw/rtl/mte_pkg.sv =====
// ----------------------------------------------------------------------------
// mte_pkg
// Shared types, symbol codes and Morse pattern tables.
// ----------------------------------------------------------------------------
`default_nettype none

package mte_pkg;

  localparam logic [1:0] SYM_DOT   = 2'd0;
  localparam logic [1:0] SYM_DASH  = 2'd1;
  localparam logic [1:0] SYM_SPACE = 2'd2;
  localparam logic [1:0] SYM_SLASH = 2'd3;

  localparam int MAX_SYMS = 6;
  localparam int CNT_W    = $clog2(MAX_SYMS + 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One byte's worth of output symbols, syms[0] goes out first.
  typedef struct packed {
    logic [CNT_W-1:0]             count;
    logic [MAX_SYMS-1:0][1:0]     syms;
  } job_t;

  // Table entry: {length, marks}; marks[0] is the first element, 1 = dash.
  localparam logic [7:0] ALPHA_CODES [26] = '{
    {3'd2, 5'b00010}, {3'd4, 5'b00001}, {3'd4, 5'b00101}, {3'd3, 5'b00001},
    {3'd1, 5'b00000}, {3'd4, 5'b00100}, {3'd3, 5'b00011}, {3'd4, 5'b00000},
    {3'd2, 5'b00000}, {3'd4, 5'b01110}, {3'd3, 5'b00101}, {3'd4, 5'b00010},
    {3'd2, 5'b00011}, {3'd2, 5'b00001}, {3'd3, 5'b00111}, {3'd4, 5'b00110},
    {3'd4, 5'b01011}, {3'd3, 5'b00010}, {3'd3, 5'b00000}, {3'd1, 5'b00001},
    {3'd3, 5'b00100}, {3'd4, 5'b01000}, {3'd3, 5'b00110}, {3'd4, 5'b01001},
    {3'd4, 5'b01101}, {3'd4, 5'b00011}
  };

  localparam logic [7:0] DIGIT_CODES [10] = '{
    {3'd5, 5'b11111}, {3'd5, 5'b11110}, {3'd5, 5'b11100}, {3'd5, 5'b11000},
    {3'd5, 5'b10000}, {3'd5, 5'b00000}, {3'd5, 5'b00001}, {3'd5, 5'b00011},
    {3'd5, 5'b00111}, {3'd5, 5'b01111}
  };

endpackage

`default_nettype wire

// ===== hw/rtl/morse_text_encoder.sv =====
// ----------------------------------------------------------------------------
// morse_text_encoder
// Text byte to Morse symbol encoder with decoupled front and back.
// ----------------------------------------------------------------------------
//  channel | valid       | stall        | payload
//  text in | in_valid_i  | in_stall_o   | text_byte_i, message_start_i
//  sym out | out_valid_o | out_stall_i  | symbol_o, run_end_o
//
//  The front takes a byte per cycle while the two-entry job queue has room.
//  The back serializer sends one symbol per cycle unless the output stalls;
//  a byte is 1 to 6 symbols (separator, up to five marks); ignored bytes, none.
//  Reset clears the tail state, the queue and the serializer; no sweep.
//  Output stalls hold the current symbol; input stalls only when full.
// ----------------------------------------------------------------------------
`default_nettype none

`include "morse_text_encoder_assert.svh"

module morse_text_encoder (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] text_byte_i,
  input  wire logic       message_start_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [1:0]      symbol_o,
  output logic            run_end_o
);

  mte_pkg::job_t push_job, pop_job;
  logic          push, pop, q_full, q_valid;

  mte_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .text_byte_i     (text_byte_i),
    .message_start_i (message_start_i),
    .q_full_i        (q_full),
    .push_o          (push),
    .job_o           (push_job)
  );

  mte_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .job_o   (pop_job)
  );

  mte_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (pop_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .symbol_o    (symbol_o),
    .run_end_o   (run_end_o)
  );

  `MTE_ASSERT(a_space_not_last, out_valid_o && symbol_o == mte_pkg::SYM_SPACE |-> !run_end_o)
  `MTE_ASSERT(a_slash_is_last, out_valid_o && symbol_o == mte_pkg::SYM_SLASH |-> run_end_o)
  `MTE_ASSERT(a_run_unbroken, out_valid_o && !out_stall_i && !run_end_o |=> out_valid_o)
  `MTE_ASSERT_ALWAYS(a_no_push_when_full, !(push && q_full && !pop))

endmodule

`default_nettype wire

// ===== hw/rtl/mte_front.sv =====
// ----------------------------------------------------------------------------
// mte_front
// Accepts text bytes, classifies them, tracks the output tail and builds
// the symbol job for each byte that emits anything.
// ----------------------------------------------------------------------------
`default_nettype none

module mte_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic [7:0]    text_byte_i,
  input  wire logic          message_start_i,
  input  wire logic          q_full_i,
  output logic               push_o,
  output mte_pkg::job_t      job_o
);

  typedef enum logic [1:0] {
    TAIL_EMPTY = 2'd0,
    TAIL_MARK  = 2'd1,
    TAIL_SPACE = 2'd2,
    TAIL_SLASH = 2'd3
  } tail_e;

  tail_e       tail_q, tail_d, tail_cur;
  logic        accept;
  logic        is_lower, is_upper, is_digit, is_space, is_code;
  logic [7:0]  off_lower, off_upper, off_digit;
  logic [7:0]  code_ent;
  logic [2:0]  code_len;
  logic [4:0]  code_marks;
  logic [4:0][1:0] mark_syms;
  logic        sep;
  logic        emit_space;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i & ~in_stall_o;

  assign is_lower = text_byte_i inside {[8'h61:8'h7a]};
  assign is_upper = text_byte_i inside {[8'h41:8'h5a]};
  assign is_digit = text_byte_i inside {[8'h30:8'h39]};
  assign is_space = (text_byte_i == 8'h20);
  assign is_code  = is_lower | is_upper | is_digit;

  assign off_lower = text_byte_i - 8'h61;
  assign off_upper = text_byte_i - 8'h41;
  assign off_digit = text_byte_i - 8'h30;

  always_comb begin
    tail_cur = message_start_i ? TAIL_EMPTY : tail_q;

    if (is_lower) begin
      code_ent = mte_pkg::ALPHA_CODES[off_lower[4:0]];
    end else if (is_upper) begin
      code_ent = mte_pkg::ALPHA_CODES[off_upper[4:0]];
    end else if (is_digit) begin
      code_ent = mte_pkg::DIGIT_CODES[off_digit[3:0]];
    end else begin
      code_ent = 8'd0;
    end
    code_len   = code_ent[7:5];
    code_marks = code_ent[4:0];

    for (int k = 0; k < 5; k++) begin
      mark_syms[k] = code_marks[k] ? mte_pkg::SYM_DASH : mte_pkg::SYM_DOT;
    end

    sep        = (tail_cur == TAIL_MARK) || (tail_cur == TAIL_SPACE);
    emit_space = is_space && ((tail_cur == TAIL_MARK) || (tail_cur == TAIL_SLASH));

    job_o  = '0;
    push_o = 1'b0;
    tail_d = tail_cur;
    if (emit_space) begin
      job_o.count   = mte_pkg::CNT_W'(2);
      job_o.syms[0] = mte_pkg::SYM_SPACE;
      job_o.syms[1] = mte_pkg::SYM_SLASH;
      push_o        = accept;
      tail_d        = TAIL_SLASH;
    end else if (is_code) begin
      job_o.count = mte_pkg::CNT_W'(code_len) + mte_pkg::CNT_W'(sep);
      job_o.syms  = sep ? {mark_syms, mte_pkg::SYM_SPACE} : {2'b00, mark_syms};
      push_o      = accept;
      tail_d      = TAIL_MARK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tail_q <= TAIL_EMPTY;
    end else if (accept) begin
      tail_q <= tail_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mte_queue.sv =====
// ----------------------------------------------------------------------------
// mte_queue
// Short register queue of symbol jobs between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module mte_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire mte_pkg::job_t job_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output mte_pkg::job_t      job_o
);

  mte_pkg::job_t                 mem_q [mte_pkg::QUEUE_DEPTH];
  logic [mte_pkg::QPTR_W-1:0]    wr_ptr_q, rd_ptr_q;
  logic [mte_pkg::QCNT_W-1:0]    count_q;

  function automatic logic [mte_pkg::QPTR_W-1:0] ptr_inc(
    input logic [mte_pkg::QPTR_W-1:0] p
  );
    if (p == mte_pkg::QPTR_W'(mte_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign full_o  = (count_q == mte_pkg::QCNT_W'(mte_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mte_back.sv =====
// ----------------------------------------------------------------------------
// mte_back
// Serializes one job at a time, one symbol per output transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module mte_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          job_valid_i,
  input  wire mte_pkg::job_t job_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic [1:0]         symbol_o,
  output logic               run_end_o
);

  logic                                busy_q, busy_d;
  logic [mte_pkg::CNT_W-1:0]           left_q, left_d;
  logic [mte_pkg::MAX_SYMS-1:0][1:0]   sh_q, sh_d;
  logic                                take, last;

  assign take  = busy_q & ~out_stall_i;
  assign last  = take & (left_q == mte_pkg::CNT_W'(1));
  assign pop_o = job_valid_i & (~busy_q | last);

  assign out_valid_o = busy_q;
  assign symbol_o    = sh_q[0];
  assign run_end_o   = (left_q == mte_pkg::CNT_W'(1));

  always_comb begin
    busy_d = busy_q;
    left_d = left_q;
    sh_d   = sh_q;
    if (take) begin
      sh_d   = {2'b00, sh_q[mte_pkg::MAX_SYMS-1:1]};
      left_d = left_q - 1'b1;
      if (last) begin
        busy_d = 1'b0;
      end
    end
    if (pop_o) begin
      busy_d = 1'b1;
      left_d = job_i.count;
      sh_d   = job_i.syms;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      left_q <= '0;
    end else begin
      busy_q <= busy_d;
      left_q <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
  end

endmodule

`default_nettype wire
